@@ rtl/core/gcdp_pkg.sv @@
// Shared types, constants and functions for the great-circle proximity unit.
`default_nettype none
package gcdp_pkg;
   localparam int unsigned AngleFracBits = 16;
   localparam int unsigned LatWidth = 24;
   localparam int unsigned LonWidth = 25;
   localparam int unsigned ThrWidth = 15;
   localparam int unsigned DistWidth = 19;
   localparam int unsigned CsrAddrWidth = 2;
   localparam int unsigned CsrDataWidth = 25;
   localparam int unsigned Iters = 30;
   localparam logic [31:0] CordicGain = 32'd652032874;
   localparam logic [26:0] DegToRadQ32 = 27'd74961321;
   localparam logic [17:0] DistScale = 18'd203872;
   localparam logic [18:0] DistMax = 19'd320256;
   localparam logic [30:0] OneQ30 = 31'h4000_0000;
   localparam logic [14:0] ThrReset = 15'd400;

   typedef enum logic [CsrAddrWidth-1:0] {
      CSR_HOME_LAT = 2'd0,
      CSR_HOME_LON = 2'd1,
      CSR_NEAR_THR = 2'd2
   } csr_index_type;

   function automatic logic signed [33:0] atan_entry(input int unsigned i);
      logic signed [33:0] t;
      case (i)
         0: t = 34'sh3243F6A8;  1: t = 34'sh1DAC6705;  2: t = 34'sh0FADBAFC;
         3: t = 34'sh07F56EA6;  4: t = 34'sh03FEAB76;  5: t = 34'sh01FFD55B;
         6: t = 34'sh00FFFAAA;  7: t = 34'sh007FFF55;  8: t = 34'sh003FFFEA;
         9: t = 34'sh001FFFFD; 10: t = 34'sh000FFFFF; 11: t = 34'sh0007FFFF;
         12: t = 34'sh0003FFFF; 13: t = 34'sh0001FFFF; 14: t = 34'sh0000FFFF;
         15: t = 34'sh00007FFF; 16: t = 34'sh00003FFF; 17: t = 34'sh00001FFF;
         18: t = 34'sh00000FFF; 19: t = 34'sh000007FF; 20: t = 34'sh000003FF;
         21: t = 34'sh000001FF; 22: t = 34'sh000000FF; 23: t = 34'sh0000007F;
         24: t = 34'sh0000003F; 25: t = 34'sh0000001F; 26: t = 34'sh0000000F;
         27: t = 34'sh00000008; 28: t = 34'sh00000004; 29: t = 34'sh00000002;
         default: t = '0;
      endcase
      return t;
   endfunction
endpackage
`default_nettype wire

@@ rtl/core/great_circle_distance_proximity_unit.sv @@
// Top level of the great-circle proximity unit: haversine distance pipeline.
// Use: a request on req_ carries a target position (signed degrees, 16
// fraction bits). Each request gives one result on rsp_: the great-circle distance to
// the home position in 1/16 km and a near flag (distance <= threshold km).
// The user must write home position and threshold through the csr_ port only while
// idle; the block itself does not enforce it. Throughput: one request per cycle while
// the output is not stalled, set by the fully pipelined CORDIC rotation and vectoring
// stages, the restoring square-root stages and the registered multipliers.
// Each CORDIC or square-root stage performs one step.
// Reset clears all valid bits and loads home 0/0 and threshold 400 km.
// When the receiver stalls (rsp_tready low) the whole pipeline holds; nothing is
// lost or repeated, and req_tready follows rsp_tready or an empty output stage.
`default_nettype none
module great_circle_distance_proximity_unit
   import gcdp_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   // [23:0] target_latitude, [48:24] target_longitude
   input  wire logic [55:0]             req_tdata,
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   // [18:0] distance, [19] is_near
   output logic [23:0]                  rsp_tdata,
   input  wire logic                    csr_we,
   input  wire logic [CsrAddrWidth-1:0] csr_index,
   input  wire logic [CsrDataWidth-1:0] csr_wdata
);
   localparam int unsigned SqBits = 61;
   localparam int unsigned SqSteps = 31;
   localparam int unsigned LatLim = 90 << AngleFracBits;
   localparam int unsigned LonLim = 180 << AngleFracBits;
   localparam int unsigned AW = LonWidth + 2;

   // stage allocation
   localparam int unsigned S_CLMP = 1;
   localparam int unsigned S_RAD0 = S_CLMP + 1;
   localparam int unsigned S_RAD1 = S_RAD0 + 1;
   localparam int unsigned S_COR0 = S_RAD1 + 1;
   localparam int unsigned S_CORE = S_COR0 + Iters - 1;
   localparam int unsigned S_M1 = S_CORE + 1;
   localparam int unsigned S_M2 = S_M1 + 1;
   localparam int unsigned S_A = S_M2 + 1;
   localparam int unsigned S_SQ0 = S_A + 1;
   localparam int unsigned S_SQE = S_SQ0 + SqSteps - 1;
   localparam int unsigned S_VEC0 = S_SQE + 1;
   localparam int unsigned S_VECE = S_VEC0 + Iters - 1;
   localparam int unsigned S_DM = S_VECE + 1;
   localparam int unsigned S_DS = S_DM + 1;
   localparam int unsigned LATENCY = S_DS;

   logic signed [LatWidth-1:0] home_lat_ff;
   logic signed [LonWidth-1:0] home_lon_ff;
   logic [ThrWidth-1:0] thr_ff;
   logic adv;
   logic [LATENCY:1] vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         home_lat_ff <= '0;
         home_lon_ff <= '0;
         thr_ff <= ThrReset;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_HOME_LAT: home_lat_ff <= csr_wdata[LatWidth-1:0];
            CSR_HOME_LON: home_lon_ff <= csr_wdata[LonWidth-1:0];
            CSR_NEAR_THR: thr_ff <= csr_wdata[ThrWidth-1:0];
            default: ;
         endcase
      end
   end

   assign adv = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = vld_ff[LATENCY];

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (adv) vld_ff <= {vld_ff[LATENCY-1:1], req_tvalid};
   end

   function automatic logic signed [AW-1:0] clampv(input logic signed [AW-1:0] v,
                                                  input logic signed [AW-1:0] lim);
      return (v > lim) ? lim : ((v < -lim) ? -lim : v);
   endfunction

   // stage 1: clamp and differences
   logic signed [AW-1:0] lat1_ff, lat2_ff, dlat_ff, dlon_ff;
   always_ff @(posedge clock) begin
      logic signed [AW-1:0] l1, l2, g1, g2, dl;
      if (adv) begin
         l1 = clampv(AW'(home_lat_ff), AW'(LatLim));
         l2 = clampv(AW'($signed(req_tdata[LatWidth-1:0])), AW'(LatLim));
         g1 = clampv(AW'(home_lon_ff), AW'(LonLim));
         g2 = clampv(AW'($signed(req_tdata[LatWidth +: LonWidth])), AW'(LonLim));
         dl = g2 - g1;
         if (dl > $signed(AW'(LonLim))) dl = dl - AW'(2 * LonLim);
         else if (dl < -$signed(AW'(LonLim))) dl = dl + AW'(2 * LonLim);
         lat1_ff <= l1;
         lat2_ff <= l2;
         dlat_ff <= l2 - l1;
         dlon_ff <= dl;
      end
   end

   // stage 2: magnitudes times deg-to-rad constant (registered products)
   localparam int unsigned PW = AW + 27;
   logic [PW-1:0] prod_ff [4];
   always_ff @(posedge clock) begin
      logic signed [AW-1:0] v [4];
      v[0] = dlat_ff; v[1] = dlon_ff; v[2] = lat1_ff; v[3] = lat2_ff;
      if (adv) begin
         for (int k = 0; k < 4; k++)
            prod_ff[k] <= PW'(v[k] < 0 ? -v[k] : v[k]) * PW'(DegToRadQ32);
      end
   end

   // stage 3: round to Q30 radians
   logic signed [33:0] zin_ff [4];
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 4; k++) begin
            int unsigned sh;
            sh = AngleFracBits + 2 + ((k < 2) ? 1 : 0);
            zin_ff[k] <= 34'((prod_ff[k] + (PW'(1) << (sh - 1))) >> sh);
         end
      end
   end

   // rotation CORDIC, four lanes, one step per stage
   logic signed [33:0] cx_ff [Iters+1][4];
   logic signed [33:0] cy_ff [Iters+1][4];
   logic signed [33:0] cz_ff [Iters+1][4];
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         cx_ff[0][k] = $signed({2'b0, CordicGain});
         cy_ff[0][k] = '0;
         cz_ff[0][k] = zin_ff[k];
      end
   end
   for (genvar i = 0; i < Iters; i++) begin : g_rot
      always_ff @(posedge clock) begin
         if (adv) begin
            for (int k = 0; k < 4; k++) begin
               if (cz_ff[i][k] >= 0) begin
                  cx_ff[i+1][k] <= cx_ff[i][k] - (cy_ff[i][k] >>> i);
                  cy_ff[i+1][k] <= cy_ff[i][k] + (cx_ff[i][k] >>> i);
                  cz_ff[i+1][k] <= cz_ff[i][k] - atan_entry(i);
               end else begin
                  cx_ff[i+1][k] <= cx_ff[i][k] + (cy_ff[i][k] >>> i);
                  cy_ff[i+1][k] <= cy_ff[i][k] - (cx_ff[i][k] >>> i);
                  cz_ff[i+1][k] <= cz_ff[i][k] + atan_entry(i);
               end
            end
         end
      end
   end

   function automatic logic [30:0] clq(input logic signed [33:0] v);
      return (v < 0) ? '0 : ((v > $signed({3'b0, OneQ30})) ? OneQ30 : v[30:0]);
   endfunction
   function automatic logic [30:0] rq(input logic [61:0] p);
      return 31'((p + 62'(1 << 29)) >> 30);
   endfunction

   // products: slat^2, slon^2, c1*c2
   logic [61:0] m_ff [3];
   always_ff @(posedge clock) begin
      logic [30:0] sl, so, c1, c2;
      sl = clq(cy_ff[Iters][0]);
      so = clq(cy_ff[Iters][1]);
      c1 = clq(cx_ff[Iters][2]);
      c2 = clq(cx_ff[Iters][3]);
      if (adv) begin
         m_ff[0] <= 62'(sl) * 62'(sl);
         m_ff[1] <= 62'(so) * 62'(so);
         m_ff[2] <= 62'(c1) * 62'(c2);
      end
   end
   logic [61:0] m2_ff;
   logic [30:0] t0_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         m2_ff <= 62'(rq(m_ff[2])) * 62'(rq(m_ff[1]));
         t0_ff <= rq(m_ff[0]);
      end
   end
   logic [30:0] a_ff;
   always_ff @(posedge clock) begin
      logic [31:0] s;
      s = 32'(t0_ff) + 32'(rq(m2_ff));
      if (adv) a_ff <= (s > 32'(OneQ30)) ? OneQ30 : s[30:0];
   end

   // two restoring square roots, two bits of radicand per stage
   logic [SqBits-1:0] qn_ff [SqSteps+1][2];
   logic [SqBits-1:0] qr_ff [SqSteps+1][2];
   always_comb begin
      qn_ff[0][0] = {a_ff, 30'b0};
      qn_ff[0][1] = {OneQ30 - a_ff, 30'b0};
      qr_ff[0][0] = '0;
      qr_ff[0][1] = '0;
   end
   for (genvar j = 0; j < SqSteps; j++) begin : g_sq
      localparam logic [SqBits-1:0] Bit = SqBits'(1) << (2 * (SqSteps - 1 - j));
      always_ff @(posedge clock) begin
         if (adv) begin
            for (int k = 0; k < 2; k++) begin
               if (qn_ff[j][k] >= qr_ff[j][k] + Bit) begin
                  qn_ff[j+1][k] <= qn_ff[j][k] - (qr_ff[j][k] + Bit);
                  qr_ff[j+1][k] <= (qr_ff[j][k] >> 1) + Bit;
               end else begin
                  qn_ff[j+1][k] <= qn_ff[j][k];
                  qr_ff[j+1][k] <= qr_ff[j][k] >> 1;
               end
            end
         end
      end
   end

   // vectoring CORDIC
   logic signed [33:0] vx_ff [Iters+1];
   logic signed [33:0] vy_ff [Iters+1];
   logic signed [33:0] vz_ff [Iters+1];
   always_comb begin
      vx_ff[0] = $signed(34'(qr_ff[SqSteps][1]));
      vy_ff[0] = $signed(34'(qr_ff[SqSteps][0]));
      vz_ff[0] = '0;
   end
   for (genvar i = 0; i < Iters; i++) begin : g_vec
      always_ff @(posedge clock) begin
         if (adv) begin
            if (vy_ff[i] >= 0) begin
               vx_ff[i+1] <= vx_ff[i] + (vy_ff[i] >>> i);
               vy_ff[i+1] <= vy_ff[i] - (vx_ff[i] >>> i);
               vz_ff[i+1] <= vz_ff[i] + atan_entry(i);
            end else begin
               vx_ff[i+1] <= vx_ff[i] - (vy_ff[i] >>> i);
               vy_ff[i+1] <= vy_ff[i] + (vx_ff[i] >>> i);
               vz_ff[i+1] <= vz_ff[i] - atan_entry(i);
            end
         end
      end
   end

   logic [50:0] dp_ff;
   always_ff @(posedge clock) begin
      logic [32:0] ang;
      ang = (vz_ff[Iters] < 0) ? '0 : vz_ff[Iters][32:0];
      if (adv) dp_ff <= 51'(ang) * 51'(DistScale);
   end

   logic [DistWidth-1:0] dist_ff;
   logic near_ff;
   always_ff @(posedge clock) begin
      logic [50:0] d;
      d = (dp_ff + 51'(1 << 29)) >> 30;
      if (d > 51'(DistMax)) d = 51'(DistMax);
      if (adv) begin
         dist_ff <= d[DistWidth-1:0];
         near_ff <= 51'(d) <= 51'({thr_ff, 4'b0});
      end
   end

   assign rsp_tdata = {4'b0, near_ff, dist_ff};

   // assertions
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed under stall");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input blocked with empty output");
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[18:0] <= DistMax)
      else $error("distance out of range");
endmodule
`default_nettype wire

@@ tb/sv/tb_great_circle_distance_proximity_unit.sv @@
// Testbench for the great-circle proximity unit: stream requests checked against a haversine model.
module tb_great_circle_distance_proximity_unit;
   import gcdp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [CsrAddrWidth-1:0] CsrUnused = 2'd3;
   localparam longint Deg = longint'(1) << AngleFracBits;
   localparam longint LatLim = 90 * Deg;
   localparam longint LonLim = 180 * Deg;
   localparam longint OneQ30L = longint'(1) << 30;
   localparam longint AtanQ30 [Iters] = '{
      'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76,
      'h01FFD55B, 'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD,
      'h000FFFFF, 'h0007FFFF, 'h0003FFFF, 'h0001FFFF, 'h0000FFFF,
      'h00007FFF, 'h00003FFF, 'h00001FFF, 'h00000FFF, 'h000007FF,
      'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F, 'h0000003F,
      'h0000001F, 'h0000000F, 'h00000008, 'h00000004, 'h00000002};

   typedef struct packed {
      logic [DistWidth-1:0] range_16th;
      logic                 near_flag;
   } proximity_type;

   class proximity_scoreboard;
      logic signed [LatWidth-1:0] home_lat;
      logic signed [LonWidth-1:0] home_lon;
      logic [ThrWidth-1:0]        near_km;
      proximity_type              pending_q[$];
      int                         mismatches;

      function new();
         home_lat = '0;
         home_lon = '0;
         near_km = ThrReset;
         mismatches = 0;
      endfunction

      function void set_reg(csr_index_type idx, logic [CsrDataWidth-1:0] value);
         case (idx)
            CSR_HOME_LAT: home_lat = value[LatWidth-1:0];
            CSR_HOME_LON: home_lon = value[LonWidth-1:0];
            CSR_NEAR_THR: near_km = value[ThrWidth-1:0];
            default: ;
         endcase
      endfunction

      function longint clip(longint v, longint lo, longint hi);
         return v < lo ? lo : (v > hi ? hi : v);
      endfunction

      function longint radians_q30(longint deg, int half);
         longint unsigned mag;
         int sh;
         mag = deg < 0 ? -deg : deg;
         sh = AngleFracBits + 2 + half;
         return longint'((mag * 64'd74961321 + (64'd1 << (sh - 1))) >> sh);
      endfunction

      function void rotate(longint ang, output longint s, output longint c);
         longint x, y, z, xs, ys;
         x = 652032874;
         y = 0;
         z = ang;
         for (int i = 0; i < Iters; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
               x -= ys; y += xs; z -= AtanQ30[i];
            end else begin
               x += ys; y -= xs; z += AtanQ30[i];
            end
         end
         s = clip(y, 0, OneQ30L);
         c = clip(x, 0, OneQ30L);
      endfunction

      function longint vector_angle(longint y, longint x);
         longint z, xs, ys;
         z = 0;
         for (int i = 0; i < Iters; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
               x += ys; y -= xs; z += AtanQ30[i];
            end else begin
               x -= ys; y += xs; z -= AtanQ30[i];
            end
         end
         return z < 0 ? 0 : z;
      endfunction

      function longint unsigned floor_sqrt(longint unsigned n);
         longint unsigned res, bitv;
         res = 0;
         bitv = 64'd1 << 62;
         while (bitv > n) bitv >>= 2;
         while (bitv != 0) begin
            if (n >= res + bitv) begin
               n -= res + bitv;
               res = (res >> 1) + bitv;
            end else begin
               res >>= 1;
            end
            bitv >>= 2;
         end
         return res;
      endfunction

      function longint unsigned qmul(longint unsigned a, longint unsigned b);
         return (a * b + (64'd1 << 29)) >> 30;
      endfunction

      function proximity_type haversine(logic signed [LatWidth-1:0] t_lat,
                                        logic signed [LonWidth-1:0] t_lon);
         longint lat1, lon1, lat2, lon2, dlat, dlon, s_lat, s_lon, c1, c2, unused, ang;
         longint unsigned a, ra, rb, span;
         proximity_type r;
         lat1 = clip(longint'(home_lat), -LatLim, LatLim);
         lon1 = clip(longint'(home_lon), -LonLim, LonLim);
         lat2 = clip(longint'(t_lat), -LatLim, LatLim);
         lon2 = clip(longint'(t_lon), -LonLim, LonLim);
         dlat = lat2 - lat1;
         dlon = lon2 - lon1;
         if (dlon > LonLim) dlon -= 2 * LonLim;
         else if (dlon < -LonLim) dlon += 2 * LonLim;
         rotate(radians_q30(dlat, 1), s_lat, unused);
         rotate(radians_q30(dlon, 1), s_lon, unused);
         rotate(radians_q30(lat1, 0), unused, c1);
         rotate(radians_q30(lat2, 0), unused, c2);
         a = qmul(s_lat, s_lat) + qmul(qmul(c1, c2), qmul(s_lon, s_lon));
         if (a > OneQ30L) a = OneQ30L;
         ra = floor_sqrt(a << 30);
         rb = floor_sqrt((OneQ30L - a) << 30);
         ang = vector_angle(longint'(ra), longint'(rb));
         span = (longint'(ang) * 64'd203872 + (64'd1 << 29)) >> 30;
         if (span > 320256) span = 320256;
         r.range_16th = span[DistWidth-1:0];
         r.near_flag = span <= longint'(near_km) * 16;
         return r;
      endfunction

      function void note_request(logic [55:0] data);
         pending_q.push_back(haversine(data[23:0], data[48:24]));
      endfunction

      task report(string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         mismatches++;
      endtask

      task check_result(logic [23:0] data);
         proximity_type e;
         if (pending_q.size() == 0) begin
            report($sformatf("unexpected result %h", data));
            return;
         end
         e = pending_q.pop_front();
         if (data[18:0] != e.range_16th)
            report($sformatf("distance %0d, expected %0d", data[18:0], e.range_16th));
         if (data[19] != e.near_flag)
            report($sformatf("is_near %0b, expected %0b", data[19], e.near_flag));
      endtask
   endclass

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [55:0]             req_tdata = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [23:0]             rsp_tdata;
   logic                    csr_we = 1'b0;
   logic [CsrAddrWidth-1:0] csr_index = '0;
   logic [CsrDataWidth-1:0] csr_wdata = '0;
   bit                      steady = 1'b0;
   proximity_scoreboard     sb = new();

   great_circle_distance_proximity_unit u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_request(req_tdata);
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
         rsp_tready <= steady || $urandom_range(99) >= 18;
      end
   end

   task automatic send(longint t_lat, longint t_lon);
      while (!steady && $urandom_range(99) < 18) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {7'd0, t_lon[LonWidth-1:0], t_lat[LatWidth-1:0]};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   task automatic write_reg(logic [CsrAddrWidth-1:0] idx, longint value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CsrDataWidth-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      sb.set_reg(csr_index_type'(idx), value[CsrDataWidth-1:0]);
      @(posedge clock);
   endtask

   task automatic configure(longint h_lat, longint h_lon, longint thr);
      write_reg(CSR_HOME_LAT, h_lat);
      write_reg(CSR_HOME_LON, h_lon);
      write_reg(CSR_NEAR_THR, thr);
   endtask

   task automatic random_burst(int count);
      longint t_lat, t_lon;
      for (int n = 0; n < count; n++) begin
         case ($urandom_range(3))
            0: begin
               t_lat = $signed(24'($urandom));
               t_lon = $signed(25'($urandom));
            end
            1: begin
               t_lat = longint'(sb.home_lat) + $signed(18'($urandom));
               t_lon = longint'(sb.home_lon) + $signed(19'($urandom));
            end
            default: begin
               t_lat = longint'($urandom_range(2 * LatLim)) - LatLim;
               t_lon = longint'($urandom_range(2 * LonLim)) - LonLim;
            end
         endcase
         send(t_lat, t_lon);
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send(0, 0);
      send(LatLim, 0);
      send(-LatLim, 0);
      send(0, LonLim);
      send(0, -LonLim);
      send(LatLim, LonLim);
      send(-LatLim, -LonLim);
      send('h7FFFFF, 'hFFFFFF);
      send(-'h800000, -'h1000000);
      send(3 * Deg + 40000, -2 * Deg);
      send(2 * Deg, 2 * Deg);
      send(-1, 1);
      drain();
      configure(45 * Deg, 170 * Deg, 20016);
      send(45 * Deg, -170 * Deg);
      send(-45 * Deg, -10 * Deg);
      send(45 * Deg, 170 * Deg);
      send(50 * Deg, 175 * Deg);
      random_burst(150);
      drain();
      configure(LatLim, -LonLim, 0);
      send(LatLim, 0);
      send(LatLim - 1, -LonLim);
      send(-LatLim, 0);
      steady = 1'b1;
      random_burst(250);
      steady = 1'b0;
      drain();
      configure('h7FFFFF, 'hFFFFFF, 'h7FFF);
      write_reg(CsrUnused, 'h1FFFFFF);
      send(0, 0);
      send(-LatLim, -LonLim);
      random_burst(200);
      drain();
      configure(-'h800000, -'h1000000, 1000);
      random_burst(200);
      drain();
      for (int p = 0; p < 3; p++) begin
         configure(longint'($urandom_range(2 * LatLim)) - LatLim,
                   longint'($urandom_range(2 * LonLim)) - LonLim,
                   $urandom_range(20016));
         random_burst(130);
         drain();
      end
      if (sb.mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("FAILURE");
      $finish;
   end
endmodule
